FILE: rtl/core/plkm_pkg.sv
`default_nettype none
package plkm_pkg;

    localparam int VALUE_BITS    = 24;
    localparam int KNOT_COUNT    = 7;
    localparam int KNOT_IDX_BITS = 3;
    localparam int SEG_MAX       = KNOT_COUNT - 1;

    // divider: quotient never exceeds the target span, so VALUE_BITS+1 bits
    localparam int QUO_BITS   = VALUE_BITS + 1;
    localparam int DIV_STAGES = 5;
    localparam int DIV_STEP   = (QUO_BITS + DIV_STAGES - 1) / DIV_STAGES;

    // select, subtract, multiply, divider stages, final add
    localparam int LANE_LAT = 3 + DIV_STAGES + 1;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef value_t knots_t [KNOT_COUNT];
    typedef logic [KNOT_IDX_BITS-1:0] knot_idx_t;

    localparam logic MODE_MAP  = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam logic SEG_SIX  = 1'b0;
    localparam logic SEG_FOUR = 1'b1;

    localparam int SIX_SEGS  = 6;
    localparam int FOUR_SEGS = 4;

    localparam knot_idx_t SIX_LO  [SEG_MAX] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
    localparam knot_idx_t SIX_HI  [SEG_MAX] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
    localparam knot_idx_t FOUR_LO [SEG_MAX] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0};
    localparam knot_idx_t FOUR_HI [SEG_MAX] = '{3'd2, 3'd3, 3'd4, 3'd6, 3'd0, 3'd0};

endpackage
`default_nettype wire

FILE: rtl/core/plkm_if.sv
`default_nettype none
interface plkm_in_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic                     channel;
    plkm_pkg::knot_idx_t      knot_index;
    plkm_pkg::value_t         source_knot;
    plkm_pkg::value_t         target_knot;
    plkm_pkg::value_t         cx_in;
    plkm_pkg::value_t         cy_in;

    modport source (output valid, mode, channel, knot_index, source_knot, target_knot,
                    cx_in, cy_in, input ready);
    modport sink   (input valid, mode, channel, knot_index, source_knot, target_knot,
                    cx_in, cy_in, output ready);
endinterface

interface plkm_out_if;
    logic             valid;
    logic             ready;
    plkm_pkg::value_t cx_out;
    plkm_pkg::value_t cy_out;
    logic             cx_valid;
    logic             cy_valid;

    modport source (output valid, cx_out, cy_out, cx_valid, cy_valid, input ready);
    modport sink   (input valid, cx_out, cy_out, cx_valid, cy_valid, output ready);
endinterface

interface plkm_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/piecewise_linear_knot_mapper.sv
`default_nettype none
// Piecewise-linear knot mapper: maps each (cx, cy) pair through a per-channel
// curve of seven source/target knots.
// Channels:
//   sample : input items. mode=load writes one knot pair (channel, knot_index;
//            index 7 ignored) and yields no result. mode=map maps cx_in/cy_in.
//   result : one item per map item: cx_out/cy_out with their valid flags.
//   cfg    : segment_mode (0 = six segments, 1 = four segments), write when idle.
// Pipeline from sample accept to result valid: select, span, multiply,
// five divider stages of five quotient bits each, offset/saturate.
// Throughput: one item per cycle while result is not held, set by the fully pipelined restoring divider.
// Stall: when result is held, the whole pipeline freezes; sample.ready drops
// only while the output stage holds an item the receiver has not taken.
// Load items travel as bubbles, so knot writes never overtake earlier maps.
// Reset: pipeline empty, segment_mode 0; knots undefined until loaded.
module piecewise_linear_knot_mapper
(
    input wire logic  clk,
    input wire logic  rst_n,
    plkm_in_if.sink   sample,
    plkm_out_if.source result,
    plkm_cfg_if.sink  cfg
);
    localparam int LAT = plkm_pkg::LANE_LAT;

    logic             seg_mode_reg;
    logic [LAT-1:0]   vld_reg;
    logic             en;
    logic             in_fire;
    plkm_pkg::knots_t src_reg [2];
    plkm_pkg::knots_t tgt_reg [2];

    // global advance: output stage empty or being taken
    assign en           = !vld_reg[LAT-1] || result.ready;
    assign sample.ready = en;
    assign in_fire      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_mode_reg <= plkm_pkg::SEG_SIX;
        else if (cfg.valid)
            seg_mode_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_fire && (sample.mode == plkm_pkg::MODE_MAP)};
    end

    // knot storage, written on load items
    always_ff @(posedge clk)
    begin
        if (in_fire && (sample.mode == plkm_pkg::MODE_LOAD) &&
            (sample.knot_index < plkm_pkg::knot_idx_t'(plkm_pkg::KNOT_COUNT)))
        begin
            src_reg[sample.channel][sample.knot_index] <= sample.source_knot;
            tgt_reg[sample.channel][sample.knot_index] <= sample.target_knot;
        end
    end

    plkm_lane u_cx
    (
        .clk      (clk),
        .en       (en),
        .seg_mode (seg_mode_reg),
        .src      (src_reg[0]),
        .tgt      (tgt_reg[0]),
        .x        (sample.cx_in),
        .value    (result.cx_out),
        .value_ok (result.cx_valid)
    );

    plkm_lane u_cy
    (
        .clk      (clk),
        .en       (en),
        .seg_mode (seg_mode_reg),
        .src      (src_reg[1]),
        .tgt      (tgt_reg[1]),
        .x        (sample.cy_in),
        .value    (result.cy_out),
        .value_ok (result.cy_valid)
    );

    assign result.valid = vld_reg[LAT-1];

    // a frozen pipeline keeps its occupancy
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_cx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.cx_valid |-> result.cx_out == '0)
        else $error("cx_out nonzero while not valid");

    a_cy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.cy_valid |-> result.cy_out == '0)
        else $error("cy_out nonzero while not valid");
endmodule
`default_nettype wire

FILE: rtl/core/plkm_lane.sv
`default_nettype none
module plkm_lane
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             seg_mode,
    input  plkm_pkg::knots_t      src,
    input  plkm_pkg::knots_t      tgt,
    input  plkm_pkg::value_t      x,
    output plkm_pkg::value_t      value,
    output logic                  value_ok
);
    localparam int V = plkm_pkg::VALUE_BITS;
    localparam int Q = plkm_pkg::QUO_BITS;
    localparam int D = plkm_pkg::DIV_STAGES;

    // stage 1: segment select
    logic             hit_reg, hit_next;
    plkm_pkg::value_t sa_reg, sa_next, sb_reg, sb_next;
    plkm_pkg::value_t ta_reg, ta_next, tb_reg, tb_next;
    plkm_pkg::value_t x_reg;

    always_comb
    begin
        plkm_pkg::knot_idx_t lo;
        plkm_pkg::knot_idx_t hi;
        int                  nseg;
        logic                top;
        hit_next = 1'b0;
        sa_next  = '0;
        sb_next  = '0;
        ta_next  = '0;
        tb_next  = '0;
        nseg     = (seg_mode == plkm_pkg::SEG_FOUR) ? plkm_pkg::FOUR_SEGS : plkm_pkg::SIX_SEGS;
        for (int s = 0; s < plkm_pkg::SEG_MAX; s++)
        begin
            lo  = (seg_mode == plkm_pkg::SEG_FOUR) ? plkm_pkg::FOUR_LO[s] : plkm_pkg::SIX_LO[s];
            hi  = (seg_mode == plkm_pkg::SEG_FOUR) ? plkm_pkg::FOUR_HI[s] : plkm_pkg::SIX_HI[s];
            top = (s == nseg - 1);
            if (!hit_next && (s < nseg) && (src[lo] <= x) &&
                (top ? (x <= src[hi]) : (x < src[hi])))
            begin
                hit_next = 1'b1;
                sa_next  = src[lo];
                sb_next  = src[hi];
                ta_next  = tgt[lo];
                tb_next  = tgt[hi];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            ta_reg  <= ta_next;
            tb_reg  <= tb_next;
            x_reg   <= x;
        end
    end

    // stage 2: spans
    logic [V-1:0]     dx_reg, dx_next, ds_reg, ds_next;
    logic [V:0]       mag_reg, mag_next;
    logic             neg2_reg, ok2_reg, ok2_next;
    plkm_pkg::value_t ta2_reg;
    logic signed [V:0] dt;
    logic [V:0]        dxw, dsw;

    always_comb
    begin
        dxw      = {x_reg[V-1], x_reg} - {sa_reg[V-1], sa_reg};
        dsw      = {sb_reg[V-1], sb_reg} - {sa_reg[V-1], sa_reg};
        dt       = {tb_reg[V-1], tb_reg} - {ta_reg[V-1], ta_reg};
        dx_next  = dxw[V-1:0];
        ds_next  = dsw[V-1:0];
        mag_next = dt[V] ? (V+1)'(-dt) : (V+1)'(dt);
        ok2_next = hit_reg && (ds_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            ds_reg   <= ds_next;
            mag_reg  <= mag_next;
            neg2_reg <= dt[V];
            ok2_reg  <= ok2_next;
            ta2_reg  <= ta_reg;
        end
    end

    // stage 3: product, then restoring divider stages
    logic [2*V:0]     prod;
    logic [V-1:0]     rem_reg [D+1];
    logic [Q-1:0]     lo_reg  [D+1];
    logic [Q-1:0]     quo_reg [D+1];
    logic [V-1:0]     dsd_reg [D+1];
    logic             negd_reg [D+1];
    logic             okd_reg  [D+1];
    plkm_pkg::value_t tad_reg  [D+1];

    assign prod = (2*V+1)'(dx_reg) * (2*V+1)'(mag_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= prod[2*V:Q];
            lo_reg[0]   <= prod[Q-1:0];
            quo_reg[0]  <= '0;
            dsd_reg[0]  <= ds_reg;
            negd_reg[0] <= neg2_reg;
            okd_reg[0]  <= ok2_reg;
            tad_reg[0]  <= ta2_reg;
        end
    end

    for (genvar d = 1; d <= D; d++)
    begin : g_div
        logic [V-1:0] rem_next;
        logic [Q-1:0] lo_next, quo_next;

        always_comb
        begin
            logic [V:0] trial;
            rem_next = rem_reg[d-1];
            lo_next  = lo_reg[d-1];
            quo_next = quo_reg[d-1];
            for (int b = 0; b < plkm_pkg::DIV_STEP; b++)
            begin
                if ((d - 1) * plkm_pkg::DIV_STEP + b < Q)
                begin
                    trial   = {rem_next, lo_next[Q-1]};
                    lo_next = {lo_next[Q-2:0], 1'b0};
                    if (trial >= {1'b0, dsd_reg[d-1]})
                    begin
                        trial    = trial - {1'b0, dsd_reg[d-1]};
                        quo_next = {quo_next[Q-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[Q-2:0], 1'b0};
                    end
                    rem_next = trial[V-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[d]  <= rem_next;
                lo_reg[d]   <= lo_next;
                quo_reg[d]  <= quo_next;
                dsd_reg[d]  <= dsd_reg[d-1];
                negd_reg[d] <= negd_reg[d-1];
                okd_reg[d]  <= okd_reg[d-1];
                tad_reg[d]  <= tad_reg[d-1];
            end
        end
    end

    // last stage: offset, saturate, zero when not valid
    plkm_pkg::value_t  val_reg, val_next;
    logic              ok_reg;
    logic signed [V+1:0] sum;

    always_comb
    begin
        sum = negd_reg[D] ? ({{2{tad_reg[D][V-1]}}, tad_reg[D]} - {1'b0, quo_reg[D]})
                          : ({{2{tad_reg[D][V-1]}}, tad_reg[D]} + {1'b0, quo_reg[D]});
        if (!okd_reg[D])
            val_next = '0;
        else if (sum[V+1:V-1] == 3'b000 || sum[V+1:V-1] == 3'b111)
            val_next = sum[V-1:0];
        else
            val_next = sum[V+1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            ok_reg  <= okd_reg[D];
        end
    end

    assign value    = val_reg;
    assign value_ok = ok_reg;
endmodule
`default_nettype wire
